// ----- hw/rtl/spd_pkg.sv -----
// Shared types, constants and controller/datapath command and status for the distance sorter.
package spd_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_W        = 16;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int SQ_W           = 2 * COORD_W;
  localparam int DIST_W         = 34;
  localparam int CFG_IDX_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_X = 1'b0,
    REG_REF_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      batch_end;
  } point_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sorted_x;
    logic signed [COORD_W-1:0] sorted_y;
    logic                      run_end;
    logic                      overflowed;
  } result_t;

  typedef struct packed {
    logic [DIST_W-1:0]         distance;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input point
    logic square;   // register squared differences
    logic add;      // register distance, set insert slot to count
    logic probe;    // read entry at slot-1
    logic shift;    // move probed entry up into slot
    logic place;    // write new entry into slot, count up
    logic drop;     // store full, flag the batch
    logic emit_rd;  // read next sorted entry for output
    logic clear;    // batch done, empty the store
  } spd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic slot_zero;
    logic greater;
    logic batch_end;
    logic emit_last;
  } spd_status_t;

endpackage

// ----- hw/rtl/sort_points_by_distance.sv -----
// Top level of the batch point sorter: orders stored points by distance to a reference.
//
// Points are loaded one per start transfer (start high while busy is low). Each point's
// squared distance to (ref_x, ref_y) is computed with the reference held at that moment
// and the point is insertion-sorted into a store of MAX_POINTS entries, so the store is
// always in ascending distance order with ties kept in load order. A load passes the
// transfer, square and sum steps, then each stored entry with a larger distance is probed
// and moves up one place; the walk ends on a compare that finds no larger distance or at
// slot zero. The single-port store is read and written once per step. Points arriving
// with the store full are dropped and the batch is flagged. The point marked batch_end is
// loaded first; then the block reads out the whole batch, one result per cycle, after
// which the store is empty again. Each result sits on result for exactly one cycle with
// result_valid high; there is no backpressure, so the receiver must take every result as
// it appears. run_end marks the last result of the batch, overflowed is set on every
// result of a batch that lost points. ref_x (index 0) and ref_y (index 1) are written
// through the configuration channel, which is always ready; write them only while busy
// is low.
module sort_points_by_distance
  import spd_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // point transfers
  input  logic                 start,
  output logic                 busy,
  input  point_in_t            item,
  // sorted results
  output logic                 result_valid,
  output result_t              result,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  spd_cmd_t    cmd;
  spd_status_t status;

  assign cfg_ready = 1'b1;

  // sequencing: load, square, sum, insertion walk, readout
  spd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // arithmetic, store and output register
  spd_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ----- hw/rtl/spd_ctrl.sv -----
// Controller state machine for the distance sorter.
module spd_ctrl
  import spd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  spd_status_t status,
  output spd_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ADD    = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_CMP    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.full) begin
          cmd.drop   = 1'b1;
          state_next = status.batch_end ? ST_EMIT : ST_IDLE;
        end else if (status.slot_zero) begin
          cmd.place  = 1'b1;
          state_next = status.batch_end ? ST_EMIT : ST_IDLE;
        end else begin
          cmd.probe  = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status.greater) begin
          cmd.shift  = 1'b1;
          state_next = ST_CHECK;
        end else begin
          cmd.place  = 1'b1;
          state_next = status.batch_end ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd.emit_rd = 1'b1;
        if (status.emit_last) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/spd_datapath.sv -----
// Datapath: reference registers, distance arithmetic, sorted point store and result register.
module spd_datapath
  import spd_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  point_in_t            item,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  spd_cmd_t             cmd,
  output spd_status_t          status,
  output result_t              result,
  output logic                 result_valid
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic signed [COORD_W-1:0] ref_x, ref_y;
  point_in_t                 pt;
  logic [SQ_W-1:0]           sqx, sqy;
  logic [DIST_W-1:0]         cur_dist;
  logic [CW-1:0]             count;
  logic                      drop;
  logic [IW-1:0]             slot;
  logic [IW-1:0]             emit_idx;
  entry_t                    mem [MAX_POINTS];
  entry_t                    rd_data;
  logic                      run_end_q, ovf_q;

  logic signed [DIFF_W-1:0]   dx, dy;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  logic [IW-1:0]              rd_addr;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REF_X: ref_x <= cfg_data;
        REG_REF_Y: ref_y <= cfg_data;
        default:   ;
      endcase
    end
  end

  // distance pipeline: difference and square, then sum
  assign dx     = {pt.point_x[COORD_W-1], pt.point_x} - {ref_x[COORD_W-1], ref_x};
  assign dy     = {pt.point_y[COORD_W-1], pt.point_y} - {ref_y[COORD_W-1], ref_y};
  assign prod_x = dx * dx;
  assign prod_y = dy * dy;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt <= item;
    end
    if (cmd.square) begin
      sqx <= prod_x[SQ_W-1:0];
      sqy <= prod_y[SQ_W-1:0];
    end
    if (cmd.add) begin
      cur_dist <= DIST_W'(sqx) + DIST_W'(sqy);
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
        drop  <= 1'b0;
      end else begin
        if (cmd.place) count <= count + CW'(1);
        if (cmd.drop)  drop  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      slot <= count[IW-1:0];
    end else if (cmd.shift) begin
      slot <= slot - IW'(1);
    end
    if (cmd.load) begin
      emit_idx <= '0;
    end else if (cmd.emit_rd) begin
      emit_idx <= emit_idx + IW'(1);
    end
  end

  // point store, kept in ascending distance order
  assign rd_addr = cmd.emit_rd ? emit_idx : (slot - IW'(1));

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      mem[slot] <= rd_data;
    end else if (cmd.place) begin
      mem[slot] <= '{distance: cur_dist, y: pt.point_y, x: pt.point_x};
    end
    if (cmd.probe || cmd.emit_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_rd;
    end
    if (cmd.emit_rd) begin
      run_end_q <= status.emit_last;
      ovf_q     <= drop;
    end
  end

  assign result.sorted_x   = rd_data.x;
  assign result.sorted_y   = rd_data.y;
  assign result.run_end    = run_end_q;
  assign result.overflowed = ovf_q;

  assign status.full      = (count == CW'(MAX_POINTS));
  assign status.slot_zero = (slot == '0);
  assign status.greater   = (rd_data.distance > cur_dist);
  assign status.batch_end = pt.batch_end;
  assign status.emit_last = ((CW'(emit_idx) + CW'(1)) == count);

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count above capacity");

  a_place_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !status.full)
    else $error("entry written into full store");

  a_shift_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> !status.slot_zero)
    else $error("shift below slot zero");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (count == '0) && !drop)
    else $error("store not emptied after batch");

endmodule
